>>> sv/assert_macros.svh
// Assertion macros shared by the decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in every cycle in which ante holds
`define ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Check that at most one bit of vec is set in every cycle in which en holds
`define ASSERT_ONEHOT0(name, clk, rstn, en, vec) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (en) |-> $onehot0(vec)) \
        else $error("one-hot check failed");

`endif

>>> sv/tcsd_pkg.sv
// Types, command codes and constants of the tuner command stream decoder
`timescale 1ns / 1ps
`default_nettype none

package tcsd_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 3;
    localparam int CLASS_W = 3;

    localparam int CMD_BYTES  = 5;
    localparam int OUT_DATA_W = 152;
    localparam int OUT_USED_W = 145;

    // command codes
    localparam logic [BYTE_W-1:0] CMD_SET_FREQ     = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_SET_RATE     = 8'd2;
    localparam logic [BYTE_W-1:0] CMD_SET_GAIN     = 8'd4;
    localparam logic [BYTE_W-1:0] CMD_SET_AGC      = 8'd8;
    localparam logic [BYTE_W-1:0] CMD_SET_GAIN_IDX = 8'd13;

    // band classes
    localparam logic [CLASS_W-1:0] BAND_NONE   = 3'd0;
    localparam logic [CLASS_W-1:0] BAND_HF     = 3'd1;
    localparam logic [CLASS_W-1:0] BAND_VHF_LO = 3'd2;
    localparam logic [CLASS_W-1:0] BAND_VHF_HI = 3'd3;
    localparam logic [CLASS_W-1:0] BAND_UHF_LO = 3'd4;
    localparam logic [CLASS_W-1:0] BAND_UHF_HI = 3'd5;
    localparam logic [CLASS_W-1:0] BAND_L      = 3'd6;

    // band edges in Hz
    localparam logic signed [VALUE_W-1:0] FREQ_MIN_HZ   = 32'sd100000;
    localparam logic signed [VALUE_W-1:0] FREQ_MAX_HZ   = 32'sd2000000000;
    localparam logic signed [VALUE_W-1:0] EDGE_60M_HZ   = 32'sd60000000;
    localparam logic signed [VALUE_W-1:0] EDGE_120M_HZ  = 32'sd120000000;
    localparam logic signed [VALUE_W-1:0] EDGE_245M_HZ  = 32'sd245000000;
    localparam logic signed [VALUE_W-1:0] EDGE_380M_HZ  = 32'sd380000000;
    localparam logic signed [VALUE_W-1:0] EDGE_430M_HZ  = 32'sd430000000;
    localparam logic signed [VALUE_W-1:0] EDGE_1G_HZ    = 32'sd1000000000;

    localparam logic signed [VALUE_W:0] RATE_TOL_HZ = 33'sd500;

    // reset settings
    localparam logic signed [VALUE_W-1:0] FREQ_RESET = 32'sd14200000;
    localparam logic signed [VALUE_W-1:0] RATE_RESET = 32'sd2048000;
    localparam logic signed [VALUE_W-1:0] GAIN_RESET = 32'sd70;

    localparam int GAIN_STEPS = 29;
    localparam int GAIN_IDX_W = 5;
    localparam int GAIN_TAB_W = 7;

    localparam logic [GAIN_TAB_W-1:0] GAIN_TABLE [0:GAIN_STEPS-1] = '{
        7'd84, 7'd81, 7'd78, 7'd75, 7'd72, 7'd69, 7'd66, 7'd63, 7'd60, 7'd57,
        7'd54, 7'd51, 7'd48, 7'd45, 7'd42, 7'd39, 7'd36, 7'd33, 7'd30, 7'd27,
        7'd24, 7'd21, 7'd18, 7'd15, 7'd12, 7'd9,  7'd6,  7'd3,  7'd0
    };

    typedef struct packed {
        logic [BYTE_W-1:0]         code;
        logic signed [VALUE_W-1:0] param;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0]         cmd_code;
        logic signed [VALUE_W-1:0] param_value;
        logic signed [VALUE_W-1:0] frequency_hz;
        logic signed [VALUE_W-1:0] sample_rate_hz;
        logic signed [VALUE_W-1:0] gain_value;
        logic                      agc_on;
        logic [CLASS_W-1:0]        freq_class;
        logic                      rate_big_change;
        logic                      freq_changed;
        logic                      rate_changed;
        logic                      gain_changed;
        logic                      cmd_ignored;
    } result_t;

endpackage

`default_nettype wire

>>> sv/tcsd_assembler.sv
// Byte assembler: collects a code byte and a big-endian 32-bit parameter
`timescale 1ns / 1ps
`default_nettype none

module tcsd_assembler (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [tcsd_pkg::BYTE_W-1:0] s_tdata,
    input  wire logic                       exec_ready,
    output logic                            cmd_valid,
    output tcsd_pkg::cmd_t                  cmd
);

    logic [tcsd_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [tcsd_pkg::BYTE_W-1:0]   code_reg, code_next;
    logic [23:0]                   shift_reg, shift_next;
    logic                          cmd_valid_reg, cmd_valid_next;
    tcsd_pkg::cmd_t                cmd_reg, cmd_next;
    logic                          accept;
    logic                          load;

    assign s_tready  = !cmd_valid_reg || exec_ready;
    assign accept    = s_tvalid && s_tready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        count_next = count_reg;
        code_next  = code_reg;
        shift_next = shift_reg;
        cmd_next   = cmd_reg;
        load       = 1'b0;
        if (accept) begin
            if (count_reg == '0) begin
                code_next  = s_tdata;
                count_next = 3'd1;
            end else if (count_reg < 3'(tcsd_pkg::CMD_BYTES - 1)) begin
                shift_next = {shift_reg[15:0], s_tdata};
                count_next = count_reg + 3'd1;
            end else begin
                count_next     = '0;
                load           = 1'b1;
                cmd_next.code  = code_reg;
                cmd_next.param = {shift_reg, s_tdata};
            end
        end
        cmd_valid_next = (cmd_valid_reg && !exec_ready) || load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            code_reg      <= '0;
            shift_reg     <= '0;
            cmd_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            code_reg      <= code_next;
            shift_reg     <= shift_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

>>> sv/tcsd_exec.sv
// Command execution: settings registers, band class, change flags, result register
`timescale 1ns / 1ps
`default_nettype none

module tcsd_exec (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cmd_valid,
    input  wire tcsd_pkg::cmd_t cmd,
    output logic                exec_ready,
    output logic                res_valid,
    input  wire logic           res_ready,
    output tcsd_pkg::result_t   res
);

    logic signed [tcsd_pkg::VALUE_W-1:0] freq_reg, freq_next;
    logic signed [tcsd_pkg::VALUE_W-1:0] rate_reg, rate_next;
    logic signed [tcsd_pkg::VALUE_W-1:0] prev_reg, prev_next;
    logic signed [tcsd_pkg::VALUE_W-1:0] gain_reg, gain_next;
    logic                                agc_reg, agc_next;
    logic                                valid_reg;
    tcsd_pkg::result_t                   res_reg, res_next;
    logic                                fch, rch, gch, ign;
    logic                                idx_ok;
    logic [tcsd_pkg::CLASS_W-1:0]        band;
    logic signed [tcsd_pkg::VALUE_W:0]   diff;
    logic                                take;

    assign exec_ready = !valid_reg || res_ready;
    assign take       = cmd_valid && exec_ready;
    assign res_valid  = valid_reg;
    assign res        = res_reg;

    assign idx_ok = (cmd.param[tcsd_pkg::VALUE_W-1:tcsd_pkg::GAIN_IDX_W] == '0)
                 && (cmd.param[tcsd_pkg::GAIN_IDX_W-1:0]
                     < 5'(tcsd_pkg::GAIN_STEPS));

    always_comb begin
        freq_next = freq_reg;
        rate_next = rate_reg;
        prev_next = prev_reg;
        gain_next = gain_reg;
        agc_next  = agc_reg;
        fch = 1'b0;
        rch = 1'b0;
        gch = 1'b0;
        ign = 1'b0;
        unique case (cmd.code)
            tcsd_pkg::CMD_SET_FREQ: begin
                freq_next = cmd.param;
                fch       = 1'b1;
            end
            tcsd_pkg::CMD_SET_RATE: begin
                prev_next = rate_reg;
                rate_next = cmd.param;
                rch       = 1'b1;
            end
            tcsd_pkg::CMD_SET_GAIN: begin
                gain_next = cmd.param;
                gch       = 1'b1;
            end
            tcsd_pkg::CMD_SET_AGC: begin
                agc_next = (cmd.param != '0);
            end
            tcsd_pkg::CMD_SET_GAIN_IDX: begin
                if (idx_ok) begin
                    gain_next = 32'(tcsd_pkg::GAIN_TABLE[cmd.param[tcsd_pkg::GAIN_IDX_W-1:0]]);
                    gch       = 1'b1;
                end else begin
                    ign = 1'b1;
                end
            end
            default: begin
                ign = 1'b1;
            end
        endcase
    end

    always_comb begin
        priority if (freq_next < tcsd_pkg::FREQ_MIN_HZ
                     || freq_next > tcsd_pkg::FREQ_MAX_HZ) begin
            band = tcsd_pkg::BAND_NONE;
        end else if (freq_next < tcsd_pkg::EDGE_60M_HZ) begin
            band = tcsd_pkg::BAND_HF;
        end else if (freq_next < tcsd_pkg::EDGE_120M_HZ) begin
            band = tcsd_pkg::BAND_VHF_LO;
        end else if (freq_next < tcsd_pkg::EDGE_245M_HZ) begin
            band = tcsd_pkg::BAND_VHF_HI;
        end else if (freq_next < tcsd_pkg::EDGE_380M_HZ) begin
            band = tcsd_pkg::BAND_UHF_LO;
        end else if (freq_next < tcsd_pkg::EDGE_430M_HZ) begin
            band = tcsd_pkg::BAND_NONE;
        end else if (freq_next < tcsd_pkg::EDGE_1G_HZ) begin
            band = tcsd_pkg::BAND_UHF_HI;
        end else begin
            band = tcsd_pkg::BAND_L;
        end
    end

    assign diff = {rate_next[tcsd_pkg::VALUE_W-1], rate_next}
                - {prev_next[tcsd_pkg::VALUE_W-1], prev_next};

    always_comb begin
        res_next.cmd_code        = cmd.code;
        res_next.param_value     = cmd.param;
        res_next.frequency_hz    = freq_next;
        res_next.sample_rate_hz  = rate_next;
        res_next.gain_value      = gain_next;
        res_next.agc_on          = agc_next;
        res_next.freq_class      = band;
        res_next.rate_big_change = (diff > tcsd_pkg::RATE_TOL_HZ)
                                || (diff < -tcsd_pkg::RATE_TOL_HZ);
        res_next.freq_changed    = fch;
        res_next.rate_changed    = rch;
        res_next.gain_changed    = gch;
        res_next.cmd_ignored     = ign;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg  <= tcsd_pkg::FREQ_RESET;
            rate_reg  <= tcsd_pkg::RATE_RESET;
            prev_reg  <= tcsd_pkg::RATE_RESET;
            gain_reg  <= tcsd_pkg::GAIN_RESET;
            agc_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (take) begin
                freq_reg <= freq_next;
                rate_reg <= rate_next;
                prev_reg <= prev_next;
                gain_reg <= gain_next;
                agc_reg  <= agc_next;
            end
            if (exec_ready) begin
                valid_reg <= cmd_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/tuner_command_stream_decoder.sv
// Tuner command stream decoder: top level
// Takes one control-stream byte per clock whenever the result side is not
// stalled, so five input transactions make up one command (code byte, then a
// big-endian 32-bit parameter). The command is held in a register behind the
// byte assembler and applied to the settings when the execution stage takes
// it, which also loads the result register. Input stalls only while both the
// command register and the result register are full and the result is not
// taken. Bytes that do not finish a command produce no result transaction.
// Settings reset to 14.2 MHz, 2.048 MS/s, gain 70 and AGC off.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tuner_command_stream_decoder (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [tcsd_pkg::BYTE_W-1:0]      s_tdata,    // data_byte
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // cmd_code, param_value, frequency_hz, sample_rate_hz, gain_value, agc_on,
    // freq_class, rate_big_change, freq_changed, rate_changed, gain_changed,
    // cmd_ignored, zero padding
    output logic [tcsd_pkg::OUT_DATA_W-1:0]       m_tdata
);

    logic              exec_ready;
    logic              cmd_valid;
    tcsd_pkg::cmd_t    cmd;
    tcsd_pkg::result_t res;

    tcsd_assembler u_assembler (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .exec_ready (exec_ready),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd)
    );

    tcsd_exec u_exec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .exec_ready (exec_ready),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {
        (tcsd_pkg::OUT_DATA_W - tcsd_pkg::OUT_USED_W)'(0),
        res.cmd_ignored,
        res.gain_changed,
        res.rate_changed,
        res.freq_changed,
        res.rate_big_change,
        res.freq_class,
        res.agc_on,
        res.gain_value,
        res.sample_rate_hz,
        res.frequency_hz,
        res.param_value,
        res.cmd_code
    };

    `ASSERT_IMPL(a_stall_from_output, aclk, aresetn, !s_tready, m_tvalid && !m_tready)
    `ASSERT_ONEHOT0(a_flags_exclusive, aclk, aresetn, m_tvalid, {res.freq_changed, res.rate_changed, res.gain_changed, res.cmd_ignored})
    `ASSERT_IMPL(a_freq_follows_cmd, aclk, aresetn, m_tvalid && res.freq_changed, res.frequency_hz == res.param_value)

endmodule

`default_nettype wire
